@@ hdl/spam_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial add/multiply package
// Shared types, constants and command/status structures.
// ----------------------------------------------------------------------------
package spam_pkg;

  localparam int MAX_TERMS = 8;
  localparam int COEF_BITS = 16;
  localparam int EXP_BITS = 8;
  localparam int TABLE_DEPTH = 64;
  localparam int CNT_BITS = $clog2(MAX_TERMS + 1);
  localparam int IDX_BITS = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TAB_BITS = $clog2(TABLE_DEPTH);
  localparam int TCNT_BITS = TAB_BITS + 1;
  localparam int SUM_EXP_BITS = EXP_BITS + 1;
  localparam int ACC_BITS = 40;
  localparam int OUT_COEF_BITS = 36;
  localparam int OUT_EXP_BITS = 9;

  typedef enum logic [2:0] {
    OP_LOAD_LEFT  = 3'd0,
    OP_LOAD_RIGHT = 3'd1,
    OP_SUM        = 3'd2,
    OP_PRODUCT    = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_TERM      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_ORDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR,
    S_PROD,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic clear_all;
    logic load_left;
    logic load_right;
    logic table_clear;
    logic prod_load;
    logic scan_reset;
    logic scan_read;
    logic scan_step;
    logic write_add;
    logic shift_read;
    logic shift_write;
    logic write_term;
    logic emit_reset;
    logic emit_read;
    logic emit_step;
    logic hold_load;
    logic out_term;
    logic term_last;
    logic out_status;
    logic [2:0] out_code;
  } cmd_t;

  typedef struct packed {
    logic left_full;
    logic left_order;
    logic right_full;
    logic right_order;
    logic pair_valid;
    logic scan_done;
    logic scan_match;
    logic scan_below;
    logic shift_done;
    logic emit_done;
    logic emit_nonzero;
    logic any_emitted;
  } stat_t;

endpackage

@@ hdl/sparse_polynomial_add_multiply_top.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial add/multiply top level
// A load, clear or rejected load keeps busy low and gives one beat in the
// cycle right after the edge that accepts it, so such commands can follow
// each other with no gap. A sum or product raises busy and builds a sorted
// table by insertion: each new term costs a scan of the entries above it and
// a shift of the entries below it. The table is then read out entry by
// entry, and busy falls with the last beat; no command is taken while busy
// is high. The receiver cannot stall; every beat shows on done for one cycle.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_multiply_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [15:0] coefficient,
  input  logic [7:0]         exponent,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [35:0] term_coefficient,
  output logic [8:0]         term_exponent,
  output logic               last
);

  spam_pkg::cmd_t cmd;
  spam_pkg::stat_t stat;
  logic is_prod;

  spam_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .stat(stat), .cmd(cmd), .is_prod(is_prod), .busy(busy)
  );

  spam_dp u_dp (
    .clk(clk), .rst(rst), .coefficient(coefficient), .exponent(exponent),
    .is_prod(is_prod), .cmd(cmd), .stat(stat), .done(done), .status(status),
    .term_coefficient(term_coefficient), .term_exponent(term_exponent),
    .last(last)
  );

endmodule

@@ hdl/spam_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial controller
// Sequences loads, table building and result emission.
// ----------------------------------------------------------------------------
module spam_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         operation,
  input  spam_pkg::stat_t    stat,
  output spam_pkg::cmd_t     cmd,
  output logic               is_prod,
  output logic               busy
);

  spam_pkg::state_t state, state_next;
  logic is_prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spam_pkg::S_IDLE;
      is_prod <= 1'b0;
    end else begin
      state <= state_next;
      is_prod <= is_prod_next;
    end
  end

  always_comb begin
    state_next = state;
    is_prod_next = is_prod;
    cmd = '0;
    busy = (state != spam_pkg::S_IDLE);
    unique case (state)
      spam_pkg::S_IDLE: begin
        if (start) begin
          priority case (operation)
            spam_pkg::OP_LOAD_LEFT: begin
              cmd.out_status = 1'b1;
              if (stat.left_full) cmd.out_code = spam_pkg::ST_FULL;
              else if (stat.left_order) cmd.out_code = spam_pkg::ST_ORDER;
              else begin
                cmd.out_code = spam_pkg::ST_ACCEPTED;
                cmd.load_left = 1'b1;
              end
            end
            spam_pkg::OP_LOAD_RIGHT: begin
              cmd.out_status = 1'b1;
              if (stat.right_full) cmd.out_code = spam_pkg::ST_FULL;
              else if (stat.right_order) cmd.out_code = spam_pkg::ST_ORDER;
              else begin
                cmd.out_code = spam_pkg::ST_ACCEPTED;
                cmd.load_right = 1'b1;
              end
            end
            spam_pkg::OP_SUM, spam_pkg::OP_PRODUCT: begin
              is_prod_next = (operation == spam_pkg::OP_PRODUCT);
              cmd.table_clear = 1'b1;
              state_next = spam_pkg::S_PAIR;
            end
            spam_pkg::OP_CLEAR: begin
              cmd.clear_all = 1'b1;
              cmd.out_status = 1'b1;
              cmd.out_code = spam_pkg::ST_ACCEPTED;
            end
            default: ;
          endcase
        end
      end
      spam_pkg::S_PAIR: begin
        if (stat.pair_valid) begin
          cmd.prod_load = 1'b1;
          state_next = spam_pkg::S_PROD;
        end else begin
          cmd.emit_reset = 1'b1;
          state_next = spam_pkg::S_EMIT_RD;
        end
      end
      spam_pkg::S_PROD: begin
        cmd.scan_reset = 1'b1;
        state_next = spam_pkg::S_SCAN_RD;
      end
      spam_pkg::S_SCAN_RD: begin
        if (stat.scan_done) begin
          state_next = spam_pkg::S_SHIFT_RD;
        end else begin
          cmd.scan_read = 1'b1;
          state_next = spam_pkg::S_SCAN;
        end
      end
      spam_pkg::S_SCAN: begin
        if (stat.scan_match) begin
          cmd.write_add = 1'b1;
          state_next = spam_pkg::S_PAIR;
        end else if (stat.scan_below) begin
          state_next = spam_pkg::S_SHIFT_RD;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = spam_pkg::S_SCAN_RD;
        end
      end
      spam_pkg::S_SHIFT_RD: begin
        if (stat.shift_done) begin
          cmd.write_term = 1'b1;
          state_next = spam_pkg::S_PAIR;
        end else begin
          cmd.shift_read = 1'b1;
          state_next = spam_pkg::S_SHIFT;
        end
      end
      spam_pkg::S_SHIFT: begin
        cmd.shift_write = 1'b1;
        state_next = spam_pkg::S_SHIFT_RD;
      end
      spam_pkg::S_EMIT_RD: begin
        if (stat.emit_done) begin
          if (stat.any_emitted) begin
            cmd.out_term = 1'b1;
            cmd.term_last = 1'b1;
          end else begin
            cmd.out_status = 1'b1;
            cmd.out_code = spam_pkg::ST_EMPTY;
          end
          state_next = spam_pkg::S_IDLE;
        end else begin
          cmd.emit_read = 1'b1;
          state_next = spam_pkg::S_EMIT;
        end
      end
      spam_pkg::S_EMIT: begin
        if (stat.emit_nonzero) begin
          cmd.out_term = stat.any_emitted;
          cmd.hold_load = 1'b1;
        end
        cmd.emit_step = 1'b1;
        state_next = spam_pkg::S_EMIT_RD;
      end
      default: state_next = spam_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == spam_pkg::S_IDLE) && start && (operation == spam_pkg::OP_SUM) |=> busy)
    else $error("sum did not start");
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_term |-> !cmd.out_status)
    else $error("term and status together");
  assert property (@(posedge clk) disable iff (rst)
    cmd.write_term |=> state == spam_pkg::S_PAIR)
    else $error("write not followed by pair");

endmodule

@@ hdl/spam_dp.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial datapath
// Term lists, product multiplier, sorted table and output registers.
// ----------------------------------------------------------------------------
module spam_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [15:0]     coefficient,
  input  logic [7:0]             exponent,
  input  logic                   is_prod,
  input  spam_pkg::cmd_t         cmd,
  output spam_pkg::stat_t        stat,
  output logic                   done,
  output logic [2:0]             status,
  output logic signed [35:0]     term_coefficient,
  output logic [8:0]             term_exponent,
  output logic                   last
);

  localparam int CB = spam_pkg::COEF_BITS;
  localparam int EB = spam_pkg::EXP_BITS;
  localparam int SE = spam_pkg::SUM_EXP_BITS;
  localparam int AB = spam_pkg::ACC_BITS;
  localparam int TB = spam_pkg::TAB_BITS;
  localparam int TC = spam_pkg::TCNT_BITS;
  localparam int CN = spam_pkg::CNT_BITS;
  localparam int IB = spam_pkg::IDX_BITS;

  logic signed [CB-1:0] lc [spam_pkg::MAX_TERMS];
  logic [EB-1:0] le [spam_pkg::MAX_TERMS];
  logic signed [CB-1:0] rc [spam_pkg::MAX_TERMS];
  logic [EB-1:0] re [spam_pkg::MAX_TERMS];
  logic [CN-1:0] lcnt, rcnt;

  logic signed [AB-1:0] tcoef [spam_pkg::TABLE_DEPTH];
  logic [SE-1:0] texp [spam_pkg::TABLE_DEPTH];
  logic [TC-1:0] tcnt;
  logic table_full;

  logic [CN-1:0] pi, pj;
  logic phase;
  logic signed [AB-1:0] ncoef;
  logic [SE-1:0] nexp;
  logic [TC-1:0] pos, sh, sh_dec;
  logic signed [AB-1:0] rd_coef;
  logic [SE-1:0] rd_exp;
  logic signed [AB-1:0] hold_coef;
  logic [SE-1:0] hold_exp;
  logic any;
  logic signed [CB-1:0] ca, cb;
  logic [EB-1:0] ea, eb;
  logic signed [2*CB-1:0] prod_full;
  logic signed [AB-1:0] mag;

  wire signed [CB-1:0] cin = coefficient[CB-1:0];
  wire [EB-1:0] ein = exponent[EB-1:0];

  assign table_full = (tcnt >= TC'(spam_pkg::TABLE_DEPTH));
  assign sh_dec = sh - 1'b1;

  assign stat.left_full = (lcnt >= CN'(spam_pkg::MAX_TERMS));
  assign stat.left_order = (lcnt != '0) && (ein >= le[IB'(lcnt - 1'b1)]);
  assign stat.right_full = (rcnt >= CN'(spam_pkg::MAX_TERMS));
  assign stat.right_order = (rcnt != '0) && (ein >= re[IB'(rcnt - 1'b1)]);
  assign stat.pair_valid = is_prod ? ((pi < lcnt) && (rcnt != '0)) :
                           phase ? (pj < rcnt) : ((pi < lcnt) || (rcnt != '0));
  assign stat.scan_done = (pos >= tcnt);
  assign stat.scan_match = (rd_exp == nexp);
  assign stat.scan_below = (rd_exp < nexp);
  assign stat.shift_done = (sh == pos) || table_full;
  assign stat.emit_done = (pos >= tcnt);
  assign stat.emit_nonzero = (rd_coef != '0);
  assign stat.any_emitted = any;

  always_comb begin
    ca = phase ? rc[IB'(pj)] : lc[IB'(pi)];
    ea = phase ? re[IB'(pj)] : le[IB'(pi)];
    cb = rc[IB'(pj)];
    eb = re[IB'(pj)];
  end

  assign prod_full = ca * cb;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      lcnt <= '0;
      rcnt <= '0;
      tcnt <= '0;
    end else begin
      if (cmd.load_left) begin
        lc[IB'(lcnt)] <= cin;
        le[IB'(lcnt)] <= ein;
        lcnt <= lcnt + 1'b1;
      end
      if (cmd.load_right) begin
        rc[IB'(rcnt)] <= cin;
        re[IB'(rcnt)] <= ein;
        rcnt <= rcnt + 1'b1;
      end
      if (cmd.table_clear) tcnt <= '0;
      else if (cmd.write_term && !table_full) tcnt <= tcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_add) begin
      tcoef[pos[TB-1:0]] <= rd_coef + ncoef;
    end else if (cmd.write_term && !table_full) begin
      tcoef[pos[TB-1:0]] <= ncoef;
      texp[pos[TB-1:0]] <= nexp;
    end else if (cmd.shift_write) begin
      tcoef[sh[TB-1:0]] <= rd_coef;
      texp[sh[TB-1:0]] <= rd_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_read || cmd.emit_read) begin
      rd_coef <= tcoef[pos[TB-1:0]];
      rd_exp <= texp[pos[TB-1:0]];
    end else if (cmd.shift_read) begin
      rd_coef <= tcoef[sh_dec[TB-1:0]];
      rd_exp <= texp[sh_dec[TB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.table_clear) begin
      pi <= '0;
      pj <= '0;
      phase <= 1'b0;
    end else if (cmd.prod_load) begin
      if (is_prod) begin
        mag <= AB'(prod_full);
        nexp <= SE'(ea) + SE'(eb);
        if (pj + 1'b1 >= rcnt) begin
          pj <= '0;
          pi <= pi + 1'b1;
        end else pj <= pj + 1'b1;
      end else begin
        if (!phase && pi >= lcnt) begin
          mag <= AB'(rc[IB'(pj)]);
          nexp <= SE'(re[IB'(pj)]);
          phase <= 1'b1;
          pj <= pj + 1'b1;
        end else begin
          mag <= AB'(ca);
          nexp <= SE'(ea);
          if (phase) pj <= pj + 1'b1;
          else begin
            pi <= pi + 1'b1;
            if (pi + 1'b1 >= lcnt) phase <= 1'b1;
          end
        end
      end
    end
  end

  assign ncoef = mag;

  always_ff @(posedge clk) begin
    if (cmd.scan_reset || cmd.emit_reset) pos <= '0;
    else if (cmd.scan_step || cmd.emit_step) pos <= pos + 1'b1;
    if (cmd.scan_reset) sh <= tcnt;
    else if (cmd.shift_write) sh <= sh_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      any <= 1'b0;
    end else begin
      done <= cmd.out_term || cmd.out_status;
      if (cmd.emit_reset) any <= 1'b0;
      else if (cmd.hold_load) any <= 1'b1;
    end
    if (cmd.hold_load) begin
      hold_coef <= rd_coef;
      hold_exp <= rd_exp;
    end
    if (cmd.out_term) begin
      status <= spam_pkg::ST_TERM;
      if (hold_coef > AB'(36'sh7FFFFFFFF)) term_coefficient <= 36'sh7FFFFFFFF;
      else if (hold_coef < -AB'(36'sh7FFFFFFFF) - 1) term_coefficient <= 36'sh800000000;
      else term_coefficient <= hold_coef[35:0];
      term_exponent <= hold_exp;
      last <= cmd.term_last;
    end else begin
      status <= cmd.out_code;
      term_coefficient <= '0;
      term_exponent <= '0;
      last <= 1'b1;
    end
  end

endmodule

@@ tb/sv/sparse_polynomial_add_multiply_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial add/multiply testbench
// Drives load, sum, product and clear commands through the start/busy
// handshake. A directed table covers the extremes and every status code, and
// random commands follow. Every result beat on done is compared with the
// queue of terms worked out by the testbench's own model of the two term
// lists and the merge table.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_multiply_top_tb;

  localparam int QUIET_LIMIT = 20000;
  localparam int DIRECTED_ROWS = 24;

  typedef struct {
    logic [2:0]  status;
    logic [35:0] coefficient;
    logic [8:0]  exponent;
    logic        last;
  } result_beat_t;

  typedef struct {
    logic [2:0]  operation;
    logic [15:0] coefficient;
    logic [7:0]  exponent;
    logic        known;
    logic [2:0]  status;
  } command_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] operation;
  logic signed [15:0] coefficient;
  logic [7:0] exponent;
  logic done;
  logic [2:0] status;
  logic signed [35:0] term_coefficient;
  logic [8:0] term_exponent;
  logic last;

  result_beat_t expected_beats[$];
  longint left_coef[spam_pkg::MAX_TERMS];
  int left_exp[spam_pkg::MAX_TERMS];
  int left_len;
  longint right_coef[spam_pkg::MAX_TERMS];
  int right_exp[spam_pkg::MAX_TERMS];
  int right_len;
  longint merge_coef[spam_pkg::TABLE_DEPTH];
  int merge_exp[spam_pkg::TABLE_DEPTH];
  int merge_len;
  command_row_t directed[DIRECTED_ROWS];
  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  logic [2:0] typed_status;
  logic typed_known;

  sparse_polynomial_add_multiply_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .coefficient(coefficient), .exponent(exponent),
    .done(done), .status(status), .term_coefficient(term_coefficient),
    .term_exponent(term_exponent), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [35:0] got,
                                 input logic [35:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic result_beat_t make_beat(input logic [2:0] st, input longint c,
                                             input int e, input logic l);
    result_beat_t b;
    longint s;
    s = c;
    if (s > 64'sd34359738367) s = 64'sd34359738367;
    if (s < -64'sd34359738368) s = -64'sd34359738368;
    b.status = st;
    b.coefficient = s[35:0];
    b.exponent = e[8:0];
    b.last = l;
    return b;
  endfunction

  function automatic void merge_in(input longint c, input int e);
    int i;
    i = 0;
    while (i < merge_len && merge_exp[i] > e) i++;
    if (i < merge_len && merge_exp[i] == e) begin
      merge_coef[i] += c;
      return;
    end
    if (merge_len >= spam_pkg::TABLE_DEPTH) return;
    for (int k = merge_len; k > i; k--) begin
      merge_coef[k] = merge_coef[k-1];
      merge_exp[k] = merge_exp[k-1];
    end
    merge_coef[i] = c;
    merge_exp[i] = e;
    merge_len++;
  endfunction

  function automatic logic [2:0] store_term(input logic to_left, input longint c,
                                            input int e);
    if (to_left) begin
      if (left_len >= spam_pkg::MAX_TERMS) return spam_pkg::ST_FULL;
      if (left_len > 0 && e >= left_exp[left_len-1]) return spam_pkg::ST_ORDER;
      left_coef[left_len] = c;
      left_exp[left_len] = e;
      left_len++;
    end else begin
      if (right_len >= spam_pkg::MAX_TERMS) return spam_pkg::ST_FULL;
      if (right_len > 0 && e >= right_exp[right_len-1]) return spam_pkg::ST_ORDER;
      right_coef[right_len] = c;
      right_exp[right_len] = e;
      right_len++;
    end
    return spam_pkg::ST_ACCEPTED;
  endfunction

  function automatic void predict_polynomial(input logic [2:0] op,
                                             input logic signed [15:0] c,
                                             input logic [7:0] e);
    int n;
    int last_at;
    case (op)
      spam_pkg::OP_LOAD_LEFT, spam_pkg::OP_LOAD_RIGHT:
        expected_beats.push_back(make_beat(store_term(op == spam_pkg::OP_LOAD_LEFT,
                                                      c, e), 0, 0, 1'b1));
      spam_pkg::OP_SUM, spam_pkg::OP_PRODUCT: begin
        merge_len = 0;
        if (op == spam_pkg::OP_SUM) begin
          for (int i = 0; i < left_len; i++) merge_in(left_coef[i], left_exp[i]);
          for (int i = 0; i < right_len; i++) merge_in(right_coef[i], right_exp[i]);
        end else begin
          for (int i = 0; i < left_len; i++)
            for (int j = 0; j < right_len; j++)
              merge_in(left_coef[i] * right_coef[j], left_exp[i] + right_exp[j]);
        end
        n = 0;
        for (int i = 0; i < merge_len; i++)
          if (merge_coef[i] != 0) begin
            expected_beats.push_back(make_beat(spam_pkg::ST_TERM, merge_coef[i],
                                               merge_exp[i], 1'b0));
            n++;
          end
        if (n == 0) expected_beats.push_back(make_beat(spam_pkg::ST_EMPTY, 0, 0, 1'b1));
        else begin
          last_at = expected_beats.size() - 1;
          expected_beats[last_at].last = 1'b1;
        end
      end
      spam_pkg::OP_CLEAR: begin
        left_len = 0;
        right_len = 0;
        merge_len = 0;
        expected_beats.push_back(make_beat(spam_pkg::ST_ACCEPTED, 0, 0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL sparse_polynomial_add_multiply_top");
        $finish;
      end
      if (done) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", status, 0);
        end else begin
          if (status != expected_beats[0].status)
            report_mismatch("status", status, expected_beats[0].status);
          if (term_coefficient != expected_beats[0].coefficient)
            report_mismatch("coefficient", term_coefficient,
                            expected_beats[0].coefficient);
          if (term_exponent != expected_beats[0].exponent)
            report_mismatch("exponent", term_exponent, expected_beats[0].exponent);
          if (last != expected_beats[0].last)
            report_mismatch("last", last, expected_beats[0].last);
          void'(expected_beats.pop_front());
        end
      end
    end
  end

  task automatic send_command(input logic [2:0] op, input logic [15:0] c,
                              input logic [7:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    coefficient <= c;
    exponent <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_polynomial(op, c, e);
    if (typed_known && expected_beats.size() > 0
        && expected_beats[expected_beats.size()-1].status != typed_status)
      report_mismatch("directed status", expected_beats[expected_beats.size()-1].status,
                      typed_status);
    typed_known = 1'b0;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() > 0) @(posedge clk);
  endtask

  task automatic send_random_command(input int phase_len);
    int pick;
    logic [7:0] e;
    pick = $urandom_range(99);
    e = (pick < 5) ? 8'($urandom) : 8'($urandom_range(phase_len));
    if (pick < 35) send_command(spam_pkg::OP_LOAD_LEFT, 16'($urandom), e);
    else if (pick < 70) send_command(spam_pkg::OP_LOAD_RIGHT, 16'($urandom), e);
    else if (pick < 80) send_command(spam_pkg::OP_SUM, 16'($urandom), 8'($urandom));
    else if (pick < 88) send_command(spam_pkg::OP_PRODUCT, 16'($urandom), 8'($urandom));
    else if (pick < 97) send_command(spam_pkg::OP_CLEAR, 16'($urandom), 8'($urandom));
    else send_command(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom));
  endtask

  task automatic load_descending(input int terms);
    int e;
    e = 255;
    for (int i = 0; i < terms; i++) begin
      e = $urandom_range(e - (terms - i) + 1, 0) ;
      send_command($urandom_range(1) ? spam_pkg::OP_LOAD_LEFT : spam_pkg::OP_LOAD_RIGHT,
                   16'($urandom), e[7:0]);
      e = (e > 0) ? e - 1 : 0;
    end
  endtask

  initial begin
    directed = '{
      '{spam_pkg::OP_SUM, 16'h0000, 8'h00, 1'b1, spam_pkg::ST_EMPTY},
      '{spam_pkg::OP_PRODUCT, 16'h0000, 8'h00, 1'b1, spam_pkg::ST_EMPTY},
      '{spam_pkg::OP_LOAD_LEFT, 16'h7fff, 8'hff, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h8000, 8'hff, 1'b1, spam_pkg::ST_ORDER},
      '{spam_pkg::OP_LOAD_LEFT, 16'h8000, 8'hfe, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h0000, 8'h80, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'hffff, 8'h40, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h0001, 8'h20, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h5555, 8'h10, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'haaaa, 8'h01, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h8000, 8'h00, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h1234, 8'h00, 1'b1, spam_pkg::ST_FULL},
      '{spam_pkg::OP_LOAD_RIGHT, 16'h8000, 8'hff, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_RIGHT, 16'h8001, 8'hfe, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_RIGHT, 16'h0000, 8'h40, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_RIGHT, 16'h7fff, 8'h00, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_SUM, 16'h0000, 8'h00, 1'b0, spam_pkg::ST_TERM},
      '{spam_pkg::OP_PRODUCT, 16'h0000, 8'h00, 1'b0, spam_pkg::ST_TERM},
      '{3'd5, 16'hffff, 8'hff, 1'b0, spam_pkg::ST_TERM},
      '{3'd7, 16'h0000, 8'h00, 1'b0, spam_pkg::ST_TERM},
      '{spam_pkg::OP_CLEAR, 16'h0000, 8'h00, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_LEFT, 16'h0005, 8'h03, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_LOAD_RIGHT, 16'hfffb, 8'h03, 1'b1, spam_pkg::ST_ACCEPTED},
      '{spam_pkg::OP_SUM, 16'h0000, 8'h00, 1'b1, spam_pkg::ST_EMPTY}
    };
    rst = 1'b1;
    start = 1'b0;
    operation = spam_pkg::OP_CLEAR;
    coefficient = '0;
    exponent = '0;
    mismatches = 0;
    left_len = 0;
    right_len = 0;
    merge_len = 0;
    typed_known = 1'b0;
    send_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[r]) begin
      typed_known = directed[r].known;
      typed_status = directed[r].status;
      send_command(directed[r].operation, directed[r].coefficient, directed[r].exponent);
    end
    drain_results();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 49 : 0;
      for (int n = 0; n < 36; n++) begin
        if ($urandom_range(9) < 2) begin
          send_command(spam_pkg::OP_CLEAR, 16'($urandom), 8'($urandom));
          load_descending($urandom_range(16, 2));
          send_command($urandom_range(1) ? spam_pkg::OP_SUM : spam_pkg::OP_PRODUCT,
                       16'h0000, 8'h00);
        end else begin
          send_random_command(255);
        end
      end
      drain_results();
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS sparse_polynomial_add_multiply_top");
    end else begin
      $display("FAIL sparse_polynomial_add_multiply_top");
    end
    $finish;
  end
endmodule
